@@ rtl/ucs_pkg.sv @@
// ucs_pkg: shared types, codes and helpers of the UC send segmenter.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package ucs_pkg;

	// limits of the configuration registers
	localparam int MTU_MIN        = 256;
	localparam int MTU_MAX        = 10240;
	localparam int RING_DEPTH_MAX = 1024;
	localparam int QUEUE_DEPTH_DEF = 2;

	// header length in words for the two header formats
	localparam logic [3:0] HDR_WORDS_9B  = 4'd5;
	localparam logic [3:0] HDR_WORDS_16B = 4'd7;

	// configuration register indexes
	localparam logic [1:0] REG_PATH_MTU      = 2'd0;
	localparam logic [1:0] REG_HEADER_FORMAT = 2'd1;
	localparam logic [1:0] REG_RING_SIZE     = 2'd2;

	// result actions
	localparam logic [2:0] ACT_IDLE      = 3'd0;
	localparam logic [2:0] ACT_PACKET    = 3'd1;
	localparam logic [2:0] ACT_FLUSH     = 3'd2;
	localparam logic [2:0] ACT_LOCAL_OK  = 3'd3;
	localparam logic [2:0] ACT_LOCAL_ERR = 3'd4;
	localparam logic [2:0] ACT_WAIT_DMA  = 3'd5;

	// request kinds
	localparam logic [2:0] KIND_SEND      = 3'd0;
	localparam logic [2:0] KIND_SEND_IMM  = 3'd1;
	localparam logic [2:0] KIND_WRITE     = 3'd2;
	localparam logic [2:0] KIND_WRITE_IMM = 3'd3;
	localparam logic [2:0] KIND_REG_MR    = 3'd4;
	localparam logic [2:0] KIND_LOCAL_INV = 3'd5;

	// UC opcodes
	localparam logic [5:0] OPC_SEND_FIRST      = 6'h20;
	localparam logic [5:0] OPC_SEND_MIDDLE     = 6'h21;
	localparam logic [5:0] OPC_SEND_LAST       = 6'h22;
	localparam logic [5:0] OPC_SEND_LAST_IMM   = 6'h23;
	localparam logic [5:0] OPC_SEND_ONLY       = 6'h24;
	localparam logic [5:0] OPC_SEND_ONLY_IMM   = 6'h25;
	localparam logic [5:0] OPC_WRITE_FIRST     = 6'h26;
	localparam logic [5:0] OPC_WRITE_MIDDLE    = 6'h27;
	localparam logic [5:0] OPC_WRITE_LAST      = 6'h28;
	localparam logic [5:0] OPC_WRITE_LAST_IMM  = 6'h29;
	localparam logic [5:0] OPC_WRITE_ONLY      = 6'h2A;
	localparam logic [5:0] OPC_WRITE_ONLY_IMM  = 6'h2B;

	// one input beat, unpacked
	typedef struct packed {
		logic        can_send;
		logic        flushing;
		logic        can_start_next;
		logic [9:0]  head_index;
		logic [9:0]  last_index;
		logic        dma_pending;
		logic [2:0]  req_kind;
		logic [31:0] req_length;
		logic        req_solicited;
		logic        req_completion_only;
		logic [23:0] req_start_psn;
		logic        invalidate_failed;
	} in_item_t;

	// classified item as it waits in the queue
	typedef struct packed {
		logic        can_send;
		logic        can_start_next;
		logic [9:0]  head_index;
		logic [9:0]  last_index;
		logic [2:0]  req_kind;
		logic        req_solicited;
		logic [23:0] start_psn;
		logic        len_fits;
		logic [13:0] len_lo;
		logic [31:0] rem_after;
		logic [2:0]  flush_act;
		logic [2:0]  local_act;
	} q_entry_t;

	// one result beat
	typedef struct packed {
		logic [2:0]  action;
		logic [5:0]  packet_opcode;
		logic [13:0] payload_bytes;
		logic [3:0]  header_words;
		logic        solicited_bit;
		logic [23:0] packet_psn;
		logic        middle_packet;
		logic        has_reth;
	} result_t;

	function automatic logic [13:0] sat_mtu(input logic [13:0] mtu);
		logic [13:0] r;
		r = mtu;
		if (mtu < 14'(MTU_MIN))
			r = 14'(MTU_MIN);
		else if (mtu > 14'(MTU_MAX))
			r = 14'(MTU_MAX);
		return r;
	endfunction

	function automatic logic [10:0] clamp_ring(input logic [10:0] size);
		logic [10:0] r;
		r = size;
		if (size > 11'(RING_DEPTH_MAX))
			r = 11'(RING_DEPTH_MAX);
		return r;
	endfunction

endpackage

@@ rtl/ucs_front.sv @@
// ucs_front: classifies an incoming request beat ahead of the queue.
// Precomputes everything that needs no sequencer state. Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_front (
	input  ucs_pkg::in_item_t  item,
	input  logic [13:0]        mtu,
	output ucs_pkg::q_entry_t  entry
);
	import ucs_pkg::*;

	always_comb begin
		entry.can_send       = item.can_send;
		entry.can_start_next = item.can_start_next;
		entry.head_index     = item.head_index;
		entry.last_index     = item.last_index;
		entry.req_kind       = item.req_kind;
		entry.req_solicited  = item.req_solicited;
		entry.start_psn      = item.req_start_psn;
		// first packet of a new message: fits in one MTU or not
		entry.len_fits       = item.req_length <= {18'd0, mtu};
		entry.len_lo         = item.req_length[13:0];
		entry.rem_after      = item.req_length - {18'd0, mtu};

		if (!item.flushing || item.last_index == item.head_index)
			entry.flush_act = ACT_IDLE;
		else if (item.dma_pending)
			entry.flush_act = ACT_WAIT_DMA;
		else
			entry.flush_act = ACT_FLUSH;

		if (!item.req_completion_only && item.invalidate_failed)
			entry.local_act = ACT_LOCAL_ERR;
		else
			entry.local_act = ACT_LOCAL_OK;
	end

endmodule

@@ rtl/ucs_queue.sv @@
// ucs_queue: short FIFO of classified items between front and back.
// Register-file storage, read at the head pointer. Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_queue #(
	parameter int DEPTH = ucs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  ucs_pkg::q_entry_t  wr_data,
	output logic               rd_valid,
	input  logic               rd_ready,
	output ucs_pkg::q_entry_t  rd_data
);
	import ucs_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign wr_ready = count_q != CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_count_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count missed a pop");

endmodule

@@ rtl/ucs_back.sv @@
// ucs_back: segmentation sequencer and result register.
// Holds send phase, ring index, bytes left and next PSN. Depends on ucs_pkg.
`timescale 1ns / 1ps

module ucs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [13:0]        mtu,
	input  logic               header_format,
	input  logic [10:0]        ring_size,
	input  logic               entry_valid,
	output logic               entry_ready,
	input  ucs_pkg::q_entry_t  entry,
	output logic               res_valid,
	input  logic               res_ready,
	output ucs_pkg::result_t   res
);
	import ucs_pkg::*;

	localparam logic [2:0] PH_IDLE         = 3'd0;
	localparam logic [2:0] PH_SEND_FIRST   = 3'd1;
	localparam logic [2:0] PH_SEND_MIDDLE  = 3'd2;
	localparam logic [2:0] PH_WRITE_FIRST  = 3'd3;
	localparam logic [2:0] PH_WRITE_MIDDLE = 3'd4;

	logic [2:0]  phase_q, phase_d;
	logic [9:0]  cur_idx_q, cur_idx_d;
	logic [31:0] rem_q, rem_d;
	logic [23:0] psn_q, psn_d;
	result_t     res_q, res_d;
	logic        res_valid_q;

	logic        pop;
	logic [10:0] idx_inc;
	logic [9:0]  idx_next;
	logic        rem_gt;
	logic [31:0] rem_sub;
	logic [3:0]  hw_base;
	logic        is_send_kind;

	assign pop         = entry_valid && (!res_valid_q || res_ready);
	assign entry_ready = !res_valid_q || res_ready;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

	assign idx_inc  = {1'b0, cur_idx_q} + 11'd1;
	assign idx_next = (idx_inc >= ring_size) ? '0 : idx_inc[9:0];
	assign rem_gt   = rem_q > {18'd0, mtu};
	assign rem_sub  = rem_q - {18'd0, mtu};
	assign hw_base  = header_format ? HDR_WORDS_16B : HDR_WORDS_9B;
	assign is_send_kind = entry.req_kind == KIND_SEND || entry.req_kind == KIND_SEND_IMM;

	always_comb begin
		phase_d   = phase_q;
		cur_idx_d = cur_idx_q;
		rem_d     = rem_q;
		psn_d     = psn_q;
		res_d     = '0;
		res_d.action = ACT_IDLE;

		if (!entry.can_send) begin
			res_d.action = entry.flush_act;
		end else if (phase_q == PH_SEND_FIRST || phase_q == PH_SEND_MIDDLE) begin
			res_d.action       = ACT_PACKET;
			res_d.packet_psn   = psn_q;
			res_d.header_words = hw_base;
			psn_d              = psn_q + 24'd1;
			if (rem_gt) begin
				res_d.payload_bytes = mtu;
				res_d.middle_packet = 1'b1;
				res_d.packet_opcode = OPC_SEND_MIDDLE;
				phase_d             = PH_SEND_MIDDLE;
				rem_d               = rem_sub;
			end else begin
				res_d.payload_bytes = rem_q[13:0];
				if (entry.req_kind == KIND_SEND) begin
					res_d.packet_opcode = OPC_SEND_LAST;
				end else begin
					res_d.packet_opcode = OPC_SEND_LAST_IMM;
					res_d.header_words  = hw_base + 4'd1;
				end
				res_d.solicited_bit = entry.req_solicited;
				phase_d             = PH_IDLE;
				cur_idx_d           = idx_next;
				rem_d               = '0;
			end
		end else if (phase_q == PH_WRITE_FIRST || phase_q == PH_WRITE_MIDDLE) begin
			res_d.action       = ACT_PACKET;
			res_d.packet_psn   = psn_q;
			res_d.header_words = hw_base;
			psn_d              = psn_q + 24'd1;
			if (rem_gt) begin
				res_d.payload_bytes = mtu;
				res_d.middle_packet = 1'b1;
				res_d.packet_opcode = OPC_WRITE_MIDDLE;
				phase_d             = PH_WRITE_MIDDLE;
				rem_d               = rem_sub;
			end else begin
				res_d.payload_bytes = rem_q[13:0];
				if (entry.req_kind == KIND_WRITE) begin
					res_d.packet_opcode = OPC_WRITE_LAST;
				end else begin
					res_d.packet_opcode = OPC_WRITE_LAST_IMM;
					res_d.header_words  = hw_base + 4'd1;
					res_d.solicited_bit = entry.req_solicited;
				end
				phase_d   = PH_IDLE;
				cur_idx_d = idx_next;
				rem_d     = '0;
			end
		end else begin
			// idle, and any unknown phase code acts as idle
			phase_d = PH_IDLE;
			if (entry.can_start_next && cur_idx_q != entry.head_index) begin
				if (entry.req_kind == KIND_REG_MR || entry.req_kind == KIND_LOCAL_INV) begin
					// local operations complete only when they are the oldest
					if (entry.last_index == cur_idx_q) begin
						cur_idx_d    = idx_next;
						res_d.action = entry.local_act;
					end
				end else if (entry.req_kind <= KIND_WRITE_IMM) begin
					res_d.action        = ACT_PACKET;
					res_d.packet_psn    = entry.start_psn;
					psn_d               = entry.start_psn + 24'd1;
					rem_d               = entry.len_fits ? '0 : entry.rem_after;
					res_d.payload_bytes = entry.len_fits ? entry.len_lo : mtu;
					res_d.header_words  = hw_base;
					if (is_send_kind) begin
						if (!entry.len_fits) begin
							res_d.packet_opcode = OPC_SEND_FIRST;
							phase_d             = PH_SEND_FIRST;
						end else begin
							if (entry.req_kind == KIND_SEND) begin
								res_d.packet_opcode = OPC_SEND_ONLY;
							end else begin
								res_d.packet_opcode = OPC_SEND_ONLY_IMM;
								res_d.header_words  = hw_base + 4'd1;
							end
							res_d.solicited_bit = entry.req_solicited;
							cur_idx_d           = idx_next;
						end
					end else begin
						res_d.has_reth     = 1'b1;
						res_d.header_words = hw_base + 4'd4;
						if (!entry.len_fits) begin
							res_d.packet_opcode = OPC_WRITE_FIRST;
							phase_d             = PH_WRITE_FIRST;
						end else begin
							if (entry.req_kind == KIND_WRITE) begin
								res_d.packet_opcode = OPC_WRITE_ONLY;
							end else begin
								res_d.packet_opcode = OPC_WRITE_ONLY_IMM;
								res_d.header_words  = hw_base + 4'd5;
								res_d.solicited_bit = entry.req_solicited;
							end
							cur_idx_d = idx_next;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cur_idx_q   <= '0;
			rem_q       <= '0;
			psn_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				cur_idx_q   <= cur_idx_d;
				rem_q       <= rem_d;
				psn_q       <= psn_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= res_d;
	end

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_WRITE_MIDDLE)
		else $error("send phase out of range");

	a_non_packet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.action != ACT_PACKET) |->
		(res_q.packet_opcode == '0 && res_q.payload_bytes == '0 && res_q.packet_psn == '0))
		else $error("descriptor fields set on a non-packet result");

	a_middle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.middle_packet) |->
		(phase_q == PH_SEND_MIDDLE || phase_q == PH_WRITE_MIDDLE))
		else $error("middle packet left sequencer outside a middle phase");

endmodule

@@ rtl/uc_send_segmenter_top.sv @@
// uc_send_segmenter_top: UC requester segmentation block, top level.
// Instantiates ucs_front, ucs_queue and ucs_back; depends on ucs_pkg.
//
// Each s_axis beat is one "make next request" event carrying the queue-pair
// flags, ring indices and the work request at the current ring index; the
// request kind rides on s_axis_tuser. Each beat yields exactly one m_axis
// beat: the action on m_axis_tuser and, for packets, the opcode, payload
// length, header words, solicited bit, PSN, middle flag and RETH flag.
// The cfg channel writes path_mtu (0), header_format (1) and ring_size (2);
// cfg_ready is always high and writes are meant for an idle block.
// A beat is stored in the queue, then in the result register. Throughput is
// one beat per cycle while m_axis_tready is high: the sequencer in ucs_back
// finishes an item per cycle with one 32-bit compare and subtract of the
// bytes still to send. A two-entry queue sits between classifier and
// sequencer; when m_axis_tready is low the result register holds, the queue
// fills, and s_axis_tready drops once both entries hold a beat. Reset clears
// the sequencer to idle, ring index, byte count and PSN to zero, and loads
// the register defaults.
`timescale 1ns / 1ps

module uc_send_segmenter_top #(
	parameter int QUEUE_DEPTH = ucs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// cfg_data: register value, low bits used by the narrower registers
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// can_send, flushing, can_start_next, head_index[10], last_index[10],
	// dma_pending, req_length[32], req_solicited, req_completion_only,
	// req_start_psn[24], invalidate_failed, zero fill
	input  logic [87:0] s_axis_tdata,
	// req_kind[3]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// packet_opcode[6], payload_bytes[14], header_words[4], solicited_bit,
	// packet_psn[24], middle_packet, has_reth, zero fill
	output logic [55:0] m_axis_tdata,
	// action[3]
	output logic [2:0]  m_axis_tuser
);
	import ucs_pkg::*;

	logic [13:0] mtu_q;
	logic        hdr_fmt_q;
	logic [10:0] ring_size_q;
	logic [13:0] eff_mtu;
	logic [10:0] eff_ring;

	in_item_t  item;
	q_entry_t  front_entry;
	q_entry_t  back_entry;
	logic      back_valid;
	logic      back_ready;
	result_t   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtu_q       <= 14'd4096;
			hdr_fmt_q   <= 1'b0;
			ring_size_q <= 11'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PATH_MTU:      mtu_q       <= cfg_data;
				REG_HEADER_FORMAT: hdr_fmt_q   <= cfg_data[0];
				REG_RING_SIZE:     ring_size_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	assign eff_mtu  = sat_mtu(mtu_q);
	assign eff_ring = clamp_ring(ring_size_q);

	assign item.can_send            = s_axis_tdata[0];
	assign item.flushing            = s_axis_tdata[1];
	assign item.can_start_next      = s_axis_tdata[2];
	assign item.head_index          = s_axis_tdata[12:3];
	assign item.last_index          = s_axis_tdata[22:13];
	assign item.dma_pending         = s_axis_tdata[23];
	assign item.req_kind            = s_axis_tuser;
	assign item.req_length          = s_axis_tdata[55:24];
	assign item.req_solicited       = s_axis_tdata[56];
	assign item.req_completion_only = s_axis_tdata[57];
	assign item.req_start_psn       = s_axis_tdata[81:58];
	assign item.invalidate_failed   = s_axis_tdata[82];

	ucs_front u_front (
		.item  (item),
		.mtu   (eff_mtu),
		.entry (front_entry)
	);

	ucs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (s_axis_tvalid),
		.wr_ready (s_axis_tready),
		.wr_data  (front_entry),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_data  (back_entry)
	);

	ucs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mtu           (eff_mtu),
		.header_format (hdr_fmt_q),
		.ring_size     (eff_ring),
		.entry_valid   (back_valid),
		.entry_ready   (back_ready),
		.entry         (back_entry),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res           (res)
	);

	assign m_axis_tuser = res.action;
	assign m_axis_tdata = {5'd0, res.has_reth, res.middle_packet, res.packet_psn,
		res.solicited_bit, res.header_words, res.payload_bytes, res.packet_opcode};

endmodule
